// File: sv/lisc_pkg.sv
`timescale 1ns / 1ps
package lisc_pkg;

  localparam int GRID = 3;
  localparam int HALF = GRID / 2;
  localparam int CNT_W = (GRID > 1) ? $clog2(GRID) : 1;

  localparam int SP_W = 15;
  localparam int POS_W = 16;
  localparam int CRD_W = 18;
  localparam int SQ_W = 34;
  localparam int SQ_STEPS = 17;
  localparam int SQ_STEP_W = 5;

  localparam int CD_W = 30;
  localparam int ANG_W = 25;
  localparam int CD_STEPS = 16;
  localparam int CD_STEP_W = 4;

  localparam logic signed [ANG_W-1:0] DEG90 = 25'sd2949120;
  localparam int ANG_MAX = 23040;

  localparam logic [1:0] REG_SPACING_X = 2'd0;
  localparam logic [1:0] REG_SPACING_Y = 2'd1;
  localparam logic [1:0] REG_SPACING_Z = 2'd2;

  typedef struct packed {
    logic vld;
    logic last;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } pt_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [SQ_W-1:0] n_xy;
    logic [SQ_W-1:0] r_xy;
    logic [SQ_W-1:0] n_all;
    logic [SQ_W-1:0] r_all;
  } sq_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic zero_az;
    logic zero_el;
    logic signed [CD_W-1:0] a_az;
    logic signed [CD_W-1:0] b_az;
    logic signed [ANG_W-1:0] z_az;
    logic signed [CD_W-1:0] a_el;
    logic signed [CD_W-1:0] b_el;
    logic signed [ANG_W-1:0] z_el;
    logic [15:0] rng;
  } cd_t;

  function automatic logic signed [ANG_W-1:0] step_angle(input logic [CD_STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      4'd0: v = 25'sd1474560;
      4'd1: v = 25'sd870484;
      4'd2: v = 25'sd459940;
      4'd3: v = 25'sd233473;
      4'd4: v = 25'sd117189;
      4'd5: v = 25'sd58652;
      4'd6: v = 25'sd29333;
      4'd7: v = 25'sd14667;
      4'd8: v = 25'sd7334;
      4'd9: v = 25'sd3667;
      4'd10: v = 25'sd1833;
      4'd11: v = 25'sd917;
      4'd12: v = 25'sd458;
      4'd13: v = 25'sd229;
      4'd14: v = 25'sd115;
      default: v = 25'sd57;
    endcase
    return v;
  endfunction

endpackage

// File: sv/lisc_pos_if.sv
`timescale 1ns / 1ps
interface lisc_pos_if;
  logic valid;
  logic ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  modport source(output valid, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// File: sv/lisc_res_if.sv
`timescale 1ns / 1ps
interface lisc_res_if;
  logic valid;
  logic ready;
  logic [15:0] azimuth;
  logic [14:0] elevation;
  logic [15:0] range_dist;
  logic last;
  modport source(output valid, azimuth, elevation, range_dist, last, input ready);
  modport sink(input valid, azimuth, elevation, range_dist, last, output ready);
endinterface

// File: sv/lisc_gen.sv
`timescale 1ns / 1ps
module lisc_gen
  import lisc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [SP_W-1:0] sp_x,
  input  logic [SP_W-1:0] sp_y,
  input  logic [SP_W-1:0] sp_z,
  lisc_pos_if.sink pos,
  output pt_t pt
);

  logic busy;
  logic signed [POS_W-1:0] px, py, pz;
  logic [CNT_W-1:0] ci, cj, ck;
  logic ci_end, cj_end, ck_end, is_end, accept;

  assign ci_end = (ci == CNT_W'(GRID - 1));
  assign cj_end = (cj == CNT_W'(GRID - 1));
  assign ck_end = (ck == CNT_W'(GRID - 1));
  assign is_end = ci_end && cj_end && ck_end;
  assign pos.ready = !busy || (en && is_end);
  assign accept = pos.valid && pos.ready;

  function automatic logic signed [CRD_W-1:0] image(input logic signed [POS_W-1:0] p,
                                                     input logic [CNT_W-1:0] c,
                                                     input logic [SP_W-1:0] sp);
    logic signed [CNT_W+1:0] coef;
    logic signed [CRD_W-1:0] off;
    coef = $signed({2'b00, c}) - $signed((CNT_W+2)'(HALF));
    off = CRD_W'(coef * $signed({1'b0, sp}));
    return CRD_W'(p) + off;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pt.vld <= 1'b0;
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else begin
      if (en) begin
        pt.vld <= busy;
        pt.last <= is_end;
        pt.x <= image(px, ci, sp_x);
        pt.y <= image(py, cj, sp_y);
        pt.z <= image(pz, ck, sp_z);
      end
      if (accept) begin
        busy <= 1'b1;
        px <= pos.pos_x;
        py <= pos.pos_y;
        pz <= pos.pos_z;
        ci <= '0;
        cj <= '0;
        ck <= '0;
      end else if (en && busy) begin
        if (is_end) busy <= 1'b0;
        ck <= ck_end ? '0 : ck + 1'b1;
        if (ck_end) begin
          cj <= cj_end ? '0 : cj + 1'b1;
          if (cj_end) ci <= ci_end ? '0 : ci + 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/lisc_sqrt_cell.sv
`timescale 1ns / 1ps
module lisc_sqrt_cell
  import lisc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [SQ_STEP_W-1:0] step,
  input  sq_t d,
  output sq_t q
);

  logic [SQ_STEP_W:0] sh;
  logic [SQ_W-1:0] bitv;
  sq_t nx;

  assign sh = (SQ_STEP_W+1)'(2 * (SQ_STEPS - 1)) - {step, 1'b0};
  assign bitv = SQ_W'(1) << sh;

  always_comb begin
    nx = d;
    if (d.n_xy >= d.r_xy + bitv) begin
      nx.n_xy = d.n_xy - (d.r_xy + bitv);
      nx.r_xy = (d.r_xy >> 1) + bitv;
    end else begin
      nx.r_xy = d.r_xy >> 1;
    end
    if (d.n_all >= d.r_all + bitv) begin
      nx.n_all = d.n_all - (d.r_all + bitv);
      nx.r_all = (d.r_all >> 1) + bitv;
    end else begin
      nx.r_all = d.r_all >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= nx;
    end
  end

endmodule

// File: sv/lisc_cordic_cell.sv
`timescale 1ns / 1ps
module lisc_cordic_cell
  import lisc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [CD_STEP_W-1:0] step,
  input  cd_t d,
  output cd_t q
);

  logic signed [ANG_W-1:0] ang;
  cd_t nx;

  assign ang = step_angle(step);

  always_comb begin
    nx = d;
    if (!d.b_az[CD_W-1]) begin
      nx.a_az = d.a_az + (d.b_az >>> step);
      nx.b_az = d.b_az - (d.a_az >>> step);
      nx.z_az = d.z_az + ang;
    end else begin
      nx.a_az = d.a_az - (d.b_az >>> step);
      nx.b_az = d.b_az + (d.a_az >>> step);
      nx.z_az = d.z_az - ang;
    end
    if (!d.b_el[CD_W-1]) begin
      nx.a_el = d.a_el + (d.b_el >>> step);
      nx.b_el = d.b_el - (d.a_el >>> step);
      nx.z_el = d.z_el + ang;
    end else begin
      nx.a_el = d.a_el - (d.b_el >>> step);
      nx.b_el = d.b_el + (d.a_el >>> step);
      nx.z_el = d.z_el - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= nx;
    end
  end

endmodule

// File: sv/lattice_image_spherical_coords_core.sv
`timescale 1ns / 1ps
// Lattice image spherical coordinates.
// Input channel pos carries one source position (pos_x, pos_y, pos_z, signed Q8.8).
// For each word the block emits GRID^3 = 27 words on channel res, one per lattice
// image, k fastest, then j, then i: azimuth and elevation in 1/128 degree, range_dist
// in Q8.8 saturated at 65535, and last set on the 27th word.
// Configuration: cfg_we writes cfg_data into spacing_x/y/z selected by cfg_index
// (0, 1, 2); other indexes are ignored. Write only while the block is idle.
// Throughput: one result per cycle while the receiver does not stall; the next input
// is taken in the cycle the last image of the current one enters the pipeline.
// The rate is set by the image generator issuing one lattice point per cycle.
// Pipeline registers from acceptance to the first result: generator, squares, sum,
// 17 square root cells, rounding, CORDIC setup, 16 CORDIC cells, output register.
// A stalled receiver freezes the whole pipeline and holds the output word.
// Reset clears all valid flags and sets every spacing to 256 (1.0).
module lattice_image_spherical_coords_core
  import lisc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [SP_W-1:0] cfg_data,
  lisc_pos_if.sink pos,
  lisc_res_if.source res
);

  logic [SP_W-1:0] sp_x, sp_y, sp_z;
  logic adv;
  pt_t pt;

  logic s1_vld, s1_last;
  logic signed [CRD_W-1:0] s1_x, s1_y, s1_z;
  logic [32:0] s1_x2, s1_y2, s1_z2;
  logic signed [2*CRD_W-1:0] x2_full, y2_full, z2_full;

  sq_t sq [SQ_STEPS+1];

  logic rd_vld, rd_last;
  logic signed [CRD_W-1:0] rd_y, rd_x, rd_z;
  logic [CRD_W-1:0] rd_rxy;
  logic [15:0] rd_dist;

  cd_t cd [CD_STEPS+1];

  logic o_vld, o_last;
  logic signed [15:0] o_az;
  logic [14:0] o_el;
  logic [15:0] o_dist;

  assign adv = !o_vld || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_x <= SP_W'(256);
      sp_y <= SP_W'(256);
      sp_z <= SP_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACING_X: sp_x <= cfg_data;
        REG_SPACING_Y: sp_y <= cfg_data;
        REG_SPACING_Z: sp_z <= cfg_data;
        default: ;
      endcase
    end
  end

  lisc_gen u_gen (
    .clk(clk), .rst(rst), .en(adv),
    .sp_x(sp_x), .sp_y(sp_y), .sp_z(sp_z),
    .pos(pos), .pt(pt)
  );

  assign x2_full = pt.x * pt.x;
  assign y2_full = pt.y * pt.y;
  assign z2_full = pt.z * pt.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      sq[0].vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= pt.vld;
      s1_last <= pt.last;
      s1_x <= pt.x;
      s1_y <= pt.y;
      s1_z <= pt.z;
      s1_x2 <= x2_full[32:0];
      s1_y2 <= y2_full[32:0];
      s1_z2 <= z2_full[32:0];
      sq[0].vld <= s1_vld;
      sq[0].last <= s1_last;
      sq[0].x <= s1_x;
      sq[0].y <= s1_y;
      sq[0].z <= s1_z;
      sq[0].n_xy <= SQ_W'(s1_x2) + SQ_W'(s1_y2);
      sq[0].n_all <= SQ_W'(s1_x2) + SQ_W'(s1_y2) + SQ_W'(s1_z2);
      sq[0].r_xy <= '0;
      sq[0].r_all <= '0;
    end
  end

  for (genvar t = 0; t < SQ_STEPS; t++) begin : g_sq
    lisc_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(adv), .step(SQ_STEP_W'(t)),
      .d(sq[t]), .q(sq[t+1])
    );
  end

  logic [SQ_W-1:0] rxy_rnd, all_rnd;
  assign rxy_rnd = sq[SQ_STEPS].r_xy + SQ_W'(sq[SQ_STEPS].n_xy > sq[SQ_STEPS].r_xy);
  assign all_rnd = sq[SQ_STEPS].r_all + SQ_W'(sq[SQ_STEPS].n_all > sq[SQ_STEPS].r_all);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (adv) begin
      rd_vld <= sq[SQ_STEPS].vld;
      rd_last <= sq[SQ_STEPS].last;
      rd_x <= sq[SQ_STEPS].x;
      rd_y <= sq[SQ_STEPS].y;
      rd_z <= sq[SQ_STEPS].z;
      rd_rxy <= rxy_rnd[CRD_W-1:0];
      rd_dist <= (all_rnd > SQ_W'(65535)) ? 16'hFFFF : all_rnd[15:0];
    end
  end

  function automatic void prep(input logic signed [CD_W-1:0] num,
                               input logic signed [CD_W-1:0] den,
                               output logic signed [CD_W-1:0] a,
                               output logic signed [CD_W-1:0] b,
                               output logic signed [ANG_W-1:0] z);
    logic signed [CD_W-1:0] a0, b0;
    a0 = den <<< 8;
    b0 = num <<< 8;
    a = a0;
    b = b0;
    z = '0;
    if (a0[CD_W-1]) begin
      if (!b0[CD_W-1]) begin
        a = b0;
        b = -a0;
        z = DEG90;
      end else begin
        a = -b0;
        b = a0;
        z = -DEG90;
      end
    end
  endfunction

  cd_t cd0;
  always_comb begin
    cd0 = '0;
    cd0.vld = rd_vld;
    cd0.last = rd_last;
    cd0.rng = rd_dist;
    cd0.zero_az = (rd_x == '0) && (rd_y == '0);
    cd0.zero_el = (rd_rxy == '0) && (rd_z == '0);
    prep(CD_W'(rd_x), CD_W'(rd_y), cd0.a_az, cd0.b_az, cd0.z_az);
    prep(CD_W'({1'b0, rd_rxy}), CD_W'(rd_z), cd0.a_el, cd0.b_el, cd0.z_el);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd[0].vld <= 1'b0;
    end else if (adv) begin
      cd[0] <= cd0;
    end
  end

  for (genvar t = 0; t < CD_STEPS; t++) begin : g_cd
    lisc_cordic_cell u_cell (
      .clk(clk), .rst(rst), .en(adv), .step(CD_STEP_W'(t)),
      .d(cd[t]), .q(cd[t+1])
    );
  end

  logic signed [ANG_W-1:0] az_r, el_r;
  logic signed [15:0] az_c;
  logic [14:0] el_c;
  assign az_r = (cd[CD_STEPS].z_az + ANG_W'(128)) >>> 8;
  assign el_r = (cd[CD_STEPS].z_el + ANG_W'(128)) >>> 8;

  always_comb begin
    if (cd[CD_STEPS].zero_az) az_c = '0;
    else if (az_r > ANG_W'(ANG_MAX)) az_c = 16'(ANG_MAX);
    else if (az_r < -ANG_W'(ANG_MAX)) az_c = -16'(ANG_MAX);
    else az_c = az_r[15:0];
    if (cd[CD_STEPS].zero_el || el_r[ANG_W-1]) el_c = '0;
    else if (el_r > ANG_W'(ANG_MAX)) el_c = 15'(ANG_MAX);
    else el_c = el_r[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= cd[CD_STEPS].vld;
      o_last <= cd[CD_STEPS].last;
      o_az <= az_c;
      o_el <= el_c;
      o_dist <= cd[CD_STEPS].rng;
    end
  end

  assign res.valid = o_vld;
  assign res.last = o_last;
  assign res.azimuth = o_az;
  assign res.elevation = o_el;
  assign res.range_dist = o_dist;

endmodule

// File: sv/lisc_checker.sv
`timescale 1ns / 1ps
module lisc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] azimuth,
  input logic [14:0] elevation,
  input logic [15:0] range_dist,
  input logic last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(azimuth) && $stable(elevation)
      && $stable(range_dist) && $stable(last))
    else $error("result word changed while stalled");

  a_az_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(azimuth) <= 16'sd23040) && ($signed(azimuth) >= -16'sd23040))
    else $error("azimuth out of range");

  a_el_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elevation <= 15'd23040)
    else $error("elevation out of range");

  a_no_out_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result word right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) && in_valid |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind lattice_image_spherical_coords_core lisc_checker u_lisc_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(pos.valid),
  .in_ready(pos.ready),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .azimuth(res.azimuth),
  .elevation(res.elevation),
  .range_dist(res.range_dist),
  .last(res.last)
);

// File: dv/lattice_image_spherical_coords_core_tb.sv
`timescale 1ns / 1ps
module lattice_image_spherical_coords_core_tb;
  import lisc_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
  } source_t;

  typedef struct packed {
    logic [15:0] azimuth;
    logic [14:0] elevation;
    logic [15:0] range_dist;
    logic last;
  } image_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SPACING_X;
  logic [SP_W-1:0] cfg_data = '0;

  lisc_pos_if pos();
  lisc_res_if res();

  lattice_image_spherical_coords_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pos(pos.sink), .res(res.source)
  );

  always #5 clk = ~clk;

  longint sp_x = 256, sp_y = 256, sp_z = 256;
  source_t sources[$];
  image_t images_due[$];
  int mismatches = 0;
  int hold_off = 0;
  bit stall_long = 1'b0;
  bit stall_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rsqrt(longint s);
    longint r = 0;
    longint lo = 0;
    longint hi = longint'(1) << 32;
    while (lo < hi) begin
      r = (lo + hi + 1) / 2;
      if (r * r <= s) lo = r;
      else hi = r - 1;
    end
    r = lo;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint cordic_angle(longint num, longint den);
    longint a, b, t, z, da, db;
    z = 0;
    if (num == 0 && den == 0) return 0;
    a = den * 256;
    b = num * 256;
    if (a < 0) begin
      if (b >= 0) begin
        t = a; a = b; b = -t; z = DEG90;
      end else begin
        t = a; a = -b; b = t; z = -DEG90;
      end
    end
    for (int i = 0; i < CD_STEPS; i++) begin
      da = fshift(b, i);
      db = fshift(a, i);
      if (b >= 0) begin
        a += da; b -= db; z += step_angle(CD_STEP_W'(i));
      end else begin
        a -= da; b += db; z -= step_angle(CD_STEP_W'(i));
      end
    end
    z = fshift(z + 128, 8);
    if (z > ANG_MAX) z = ANG_MAX;
    if (z < -ANG_MAX) z = -ANG_MAX;
    return z;
  endfunction

  function automatic void predict_images(source_t s);
    longint x, y, z, sxy, rxy, d, az, el;
    image_t im;
    int n;
    n = 0;
    for (int i = 0; i < GRID; i++)
      for (int j = 0; j < GRID; j++)
        for (int k = 0; k < GRID; k++) begin
          x = longint'($signed(s.px)) + (i - HALF) * sp_x;
          y = longint'($signed(s.py)) + (j - HALF) * sp_y;
          z = longint'($signed(s.pz)) + (k - HALF) * sp_z;
          sxy = x * x + y * y;
          rxy = rsqrt(sxy);
          d = rsqrt(sxy + z * z);
          az = cordic_angle(x, y);
          el = cordic_angle(rxy, z);
          if (el < 0) el = 0;
          if (d > 65535) d = 65535;
          im.azimuth = az[15:0];
          im.elevation = el[14:0];
          im.range_dist = d[15:0];
          n++;
          im.last = (n == GRID * GRID * GRID);
          images_due.push_back(im);
        end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pos.valid <= 1'b0;
      {pos.pos_x, pos.pos_y, pos.pos_z} <= '0;
    end else if (pos.valid && pos.ready) begin
      predict_images({pos.pos_x, pos.pos_y, pos.pos_z});
      send_gap = pick_gap();
      if (sources.size() > 0 && send_gap == 0) begin
        {pos.pos_x, pos.pos_y, pos.pos_z} <= sources.pop_front();
      end else begin
        pos.valid <= 1'b0;
      end
    end else if (!pos.valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (sources.size() > 0) begin
        {pos.pos_x, pos.pos_y, pos.pos_z} <= sources.pop_front();
        pos.valid <= 1'b1;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (stall_long && !stall_done) begin
      stall_done <= 1'b1;
      hold_off <= 400;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    image_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (images_due.size() == 0) begin
          report("unexpected word", res.azimuth, 0);
        end else begin
          want = images_due.pop_front();
          if (res.azimuth !== want.azimuth)
            report("azimuth", $signed(res.azimuth), $signed(want.azimuth));
          if (res.elevation !== want.elevation)
            report("elevation", res.elevation, want.elevation);
          if (res.range_dist !== want.range_dist)
            report("range_dist", res.range_dist, want.range_dist);
          if (res.last !== want.last) report("last", res.last, want.last);
        end
      end
      if (hold_off > 0) begin
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res.ready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        res.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [SP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPACING_X: sp_x = v;
      REG_SPACING_Y: sp_y = v;
      REG_SPACING_Z: sp_z = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sources.size() > 0 || pos.valid || images_due.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom_range(0, 2047) - 1024);
    if (r == 3) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return 16'($urandom());
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++)
      sources.push_back({rand_coord(), rand_coord(), rand_coord()});
    drain();
  endtask

  function automatic int azimuth_pick(int p);
    return (p == 2) ? 50 : 85;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sources.push_back({16'h0000, 16'h0000, 16'h0000});
    sources.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
    sources.push_back({16'h8000, 16'h8000, 16'h8000});
    sources.push_back({16'h7FFF, 16'h8000, 16'h0100});
    sources.push_back({16'h0000, 16'hFF00, 16'h0000});
    sources.push_back({16'h0100, 16'h0000, 16'hFF00});
    sources.push_back({16'hFFFF, 16'h0001, 16'h5555});
    sources.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
    drain();
    write_reg(REG_SPACING_X, '0);
    write_reg(REG_SPACING_Y, '0);
    write_reg(REG_SPACING_Z, '0);
    sources.push_back({16'h0000, 16'h0000, 16'h0000});
    sources.push_back({16'h0000, 16'h8000, 16'h0000});
    sources.push_back({16'h8000, 16'h0000, 16'h7FFF});
    drain();
    write_reg(REG_SPACING_X, 15'h7FFF);
    write_reg(REG_SPACING_Y, 15'h7FFF);
    write_reg(REG_SPACING_Z, 15'h7FFF);
    write_reg(REG_NONE, 15'h1234);
    sources.push_back({16'h7FFF, 16'h8000, 16'h0000});
    sources.push_back({16'h0000, 16'h0000, 16'h0000});
    drain();
    stall_long = 1'b1;
    random_phase(120);
    write_reg(REG_SPACING_X, 15'd256);
    write_reg(REG_SPACING_Y, 15'd256);
    write_reg(REG_SPACING_Z, 15'd256);
    random_phase(120);
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_SPACING_X, SP_W'($urandom()));
      write_reg(REG_SPACING_Y, SP_W'($urandom()));
      write_reg(REG_SPACING_Z, SP_W'($urandom_range(0, 2048)));
      random_phase(azimuth_pick(p));
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
